// File: sv/bdsb_pkg.sv
// ============================================================================
// bdsb_pkg: shared types and constants of the billboard depth sorter
// Entry, request and result records, register map and control codes.
// ============================================================================
package bdsb_pkg;

    localparam int MAX_ITEMS_DEF = 64;
    localparam int POS_W         = 24;
    localparam int ABS_W         = 24;
    localparam int SQ_W          = 2 * ABS_W;
    localparam int DIST_W        = SQ_W + 2;
    localparam int TAG_W         = 16;
    localparam int BLEND_W       = 8;
    localparam int SLOT_W        = 6;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;

    typedef enum logic [1:0] {
        REG_CAMERA_X = 2'd0,
        REG_CAMERA_Y = 2'd1,
        REG_CAMERA_Z = 2'd2
    } reg_index_t;

    typedef enum logic {
        ST_LOAD  = 1'b0,
        ST_DRAIN = 1'b1
    } sort_state_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [BLEND_W-1:0]      blend_mode;
        logic [TAG_W-1:0]        instance_tag;
        logic                    set_end;
    } in_item_t;

    typedef struct packed {
        logic [TAG_W-1:0]  out_tag;
        logic [SLOT_W-1:0] sorted_slot;
        logic              additive;
        logic              batch_start;
        logic              run_last;
        logic              overflow;
    } out_item_t;

    typedef struct packed {
        logic [DIST_W-1:0] dist_sq;
        logic              additive;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    typedef struct packed {
        entry_t entry;
        logic   set_end;
    } ins_req_t;

    typedef struct packed {
        logic ins_en;
        logic drain;
    } cell_ctrl_t;

endpackage

// File: sv/bdsb_dist.sv
// ============================================================================
// bdsb_dist: squared camera distance pipeline
// Three stages: absolute axis differences, squares, and their sum.
// ============================================================================
module bdsb_dist (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  bdsb_pkg::in_item_t                   in_item,
    input  logic signed [bdsb_pkg::POS_W-1:0]    cam_x,
    input  logic signed [bdsb_pkg::POS_W-1:0]    cam_y,
    input  logic signed [bdsb_pkg::POS_W-1:0]    cam_z,
    output logic                                 out_valid,
    output bdsb_pkg::ins_req_t                   out_req
);
    import bdsb_pkg::*;

    logic signed [POS_W:0] dx, dy, dz;
    logic [ABS_W-1:0] ax_reg, ay_reg, az_reg, ax_next, ay_next, az_next;
    logic [SQ_W-1:0]  sx_reg, sy_reg, sz_reg, sx_next, sy_next, sz_next;
    logic [DIST_W-1:0] dist_reg, dist_next;
    logic v1_reg, v2_reg, v3_reg;
    logic [TAG_W-1:0] tag1_reg, tag2_reg, tag3_reg;
    logic add1_reg, add2_reg, add3_reg;
    logic end1_reg, end2_reg, end3_reg;

    always_comb
    begin
        dx = {in_item.pos_x[POS_W-1], in_item.pos_x} - {cam_x[POS_W-1], cam_x};
        dy = {in_item.pos_y[POS_W-1], in_item.pos_y} - {cam_y[POS_W-1], cam_y};
        dz = {in_item.pos_z[POS_W-1], in_item.pos_z} - {cam_z[POS_W-1], cam_z};
        ax_next = dx[POS_W] ? ABS_W'(-dx) : ABS_W'(dx);
        ay_next = dy[POS_W] ? ABS_W'(-dy) : ABS_W'(dy);
        az_next = dz[POS_W] ? ABS_W'(-dz) : ABS_W'(dz);
        sx_next = ax_reg * ax_reg;
        sy_next = ay_reg * ay_reg;
        sz_next = az_reg * az_reg;
        dist_next = DIST_W'(sx_reg) + DIST_W'(sy_reg) + DIST_W'(sz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        az_reg   <= az_next;
        tag1_reg <= in_item.instance_tag;
        add1_reg <= (in_item.blend_mode != '0);
        end1_reg <= in_item.set_end;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        sz_reg   <= sz_next;
        tag2_reg <= tag1_reg;
        add2_reg <= add1_reg;
        end2_reg <= end1_reg;
        dist_reg <= dist_next;
        tag3_reg <= tag2_reg;
        add3_reg <= add2_reg;
        end3_reg <= end2_reg;
    end

    assign out_valid              = v3_reg;
    assign out_req.entry.dist_sq  = dist_reg;
    assign out_req.entry.additive = add3_reg;
    assign out_req.entry.tag      = tag3_reg;
    assign out_req.set_end        = end3_reg;

endmodule

// File: sv/bdsb_cell.sv
// ============================================================================
// bdsb_cell: one slot of the sorted chain
// Takes the new entry, its left neighbor's entry, or its right neighbor's, or holds its own.
// ============================================================================
module bdsb_cell (
    input  logic                   clk,
    input  bdsb_pkg::cell_ctrl_t   ctrl,
    input  logic                   in_list,
    input  bdsb_pkg::entry_t       new_entry,
    input  bdsb_pkg::entry_t       prev_entry,
    input  logic                   prev_ins,
    input  bdsb_pkg::entry_t       next_entry,
    output bdsb_pkg::entry_t       entry,
    output logic                   ins
);
    import bdsb_pkg::*;

    entry_t entry_reg, entry_next;
    logic   beats;

    always_comb
    begin
        if (new_entry.additive != entry_reg.additive)
        begin
            beats = new_entry.additive;
        end
        else
        begin
            beats = new_entry.dist_sq > entry_reg.dist_sq;
        end
        ins = !in_list || beats;
        entry_next = entry_reg;
        if (ctrl.drain)
        begin
            entry_next = next_entry;
        end
        else if (ctrl.ins_en && ins)
        begin
            entry_next = prev_ins ? prev_entry : new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: sv/billboard_depth_sort_batcher_unit.sv
// ============================================================================
// billboard_depth_sort_batcher_unit: back-to-front particle sorter
// Sorts particles by blend group and camera distance in a chain of cells.
// ============================================================================
// A particle passes the distance pipeline before it is inserted; on set_end
// the chain drains through the result register, one result per cycle.
// Throughput: one particle per cycle while busy is low; busy stays high from
// the set_end transfer until the last of its results.
// Reset clears the camera registers, the entry count and the drop flag.
// The receiver cannot stall: each result is valid for exactly one cycle.
module billboard_depth_sort_batcher_unit #(
    parameter int MAX_ITEMS = bdsb_pkg::MAX_ITEMS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bdsb_pkg::in_item_t            item,
    output logic                          result_valid,
    output bdsb_pkg::out_item_t           result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bdsb_pkg::ADDR_W-1:0]   paddr,
    input  logic [bdsb_pkg::DATA_W-1:0]   pwdata,
    output logic [bdsb_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import bdsb_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic signed [POS_W-1:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic        wr_en;
    reg_index_t  reg_idx;

    sort_state_t state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              dropped_reg, dropped_next;
    logic              busy_reg, busy_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              prev_add_reg, prev_add_next;
    logic              res_valid_reg, res_valid_next;
    out_item_t         res_reg, res_next;

    logic       accept;
    logic       req_valid;
    ins_req_t   req;
    logic       full;
    logic       last_out;
    cell_ctrl_t ctrl;

    entry_t entries [MAX_ITEMS];
    logic   ins     [MAX_ITEMS];

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_CAMERA_X: cam_x_reg <= pwdata[POS_W-1:0];
                REG_CAMERA_Y: cam_y_reg <= pwdata[POS_W-1:0];
                REG_CAMERA_Z: cam_z_reg <= pwdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_CAMERA_X: prdata = DATA_W'(cam_x_reg);
            REG_CAMERA_Y: prdata = DATA_W'(cam_y_reg);
            REG_CAMERA_Z: prdata = DATA_W'(cam_z_reg);
            default:      prdata = '0;
        endcase
    end

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    bdsb_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_item   (item),
        .cam_x     (cam_x_reg),
        .cam_y     (cam_y_reg),
        .cam_z     (cam_z_reg),
        .out_valid (req_valid),
        .out_req   (req)
    );

    assign full     = (count_reg == CNT_W'(MAX_ITEMS));
    assign last_out = (count_reg == CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (req_valid && req.set_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (last_out)
                begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        ctrl.ins_en    = 1'b0;
        ctrl.drain     = 1'b0;
        count_next     = count_reg;
        dropped_next   = dropped_reg;
        busy_next      = busy_reg || (accept && item.set_end);
        slot_next      = slot_reg;
        prev_add_next  = prev_add_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (req_valid)
                begin
                    if (full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.ins_en = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                ctrl.drain           = 1'b1;
                res_valid_next       = 1'b1;
                res_next.out_tag     = entries[0].tag;
                res_next.sorted_slot = slot_reg;
                res_next.additive    = entries[0].additive;
                res_next.batch_start = (slot_reg == '0) ||
                                       (entries[0].additive != prev_add_reg);
                res_next.run_last    = last_out;
                res_next.overflow    = dropped_reg;
                prev_add_next        = entries[0].additive;
                slot_next            = slot_reg + SLOT_W'(1);
                count_next           = count_reg - CNT_W'(1);
                if (last_out)
                begin
                    slot_next    = '0;
                    dropped_next = 1'b0;
                    busy_next    = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            busy_reg      <= 1'b0;
            slot_reg      <= '0;
            prev_add_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dropped_reg   <= dropped_next;
            busy_reg      <= busy_next;
            slot_reg      <= slot_next;
            prev_add_reg  <= prev_add_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        entry_t prev_e;
        entry_t next_e;
        logic   prev_i;

        if (i == 0)
        begin : g_first
            assign prev_e = req.entry;
            assign prev_i = 1'b0;
        end
        else
        begin : g_mid
            assign prev_e = entries[i-1];
            assign prev_i = ins[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_last
            assign next_e = req.entry;
        end
        else
        begin : g_inner
            assign next_e = entries[i+1];
        end

        bdsb_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .in_list    (CNT_W'(i) < count_reg),
            .new_entry  (req.entry),
            .prev_entry (prev_e),
            .prev_ins   (prev_i),
            .next_entry (next_e),
            .entry      (entries[i]),
            .ins        (ins[i])
        );
    end

endmodule
